// ===== design/pmdio_pkg.sv =====
// shared types, codes and helpers of the paged phy mdio access block
package pmdio_pkg;

    // request kinds carried in the input tuser
    localparam logic [1:0] REQ_ACCESS   = 2'd0;
    localparam logic [1:0] REQ_READBACK = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // result kinds carried in the output tuser
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_REQ  = 3'd1;
    localparam logic [2:0] ST_NOT_OWN  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_ALL_ONES = 3'd4;
    localparam logic [2:0] ST_ERR_BIT  = 3'd5;
    localparam logic [2:0] ST_ECHO     = 3'd6;
    localparam logic [2:0] ST_BUSY     = 3'd7;

    // configuration register indexes
    localparam logic CFG_OWNED   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    // page map
    localparam logic [9:0] HIGH_PAGE_LO  = 10'd768;
    localparam logic [9:0] HIGH_PAGE_END = 10'd800;
    localparam logic [4:0] SELECT_REG    = 5'd31;
    localparam logic [4:0] LAST_LOW_REG  = 5'd15;
    localparam logic [1:0] ADDR_HIGH     = 2'd1;
    localparam logic [1:0] ADDR_LOW      = 2'd2;

    // command / readback word bit positions
    localparam int CMD_WRITE_BIT = 26;
    localparam int CMD_READ_BIT  = 27;
    localparam int RB_READY_BIT  = 28;
    localparam int RB_ERROR_BIT  = 30;

    typedef struct packed {
        logic [31:0] mdic_read;
        logic        is_write;
        logic [15:0] write_data;
        logic [4:0]  phy_reg;
        logic [9:0]  page;
        logic [1:0]  req_type;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [27:0] cmd;
        logic [2:0]  status;
        logic [15:0] rdata;
    } t_result;

    // build one command word: addr at bit 21, reg at bit 16
    function automatic logic [27:0] make_cmd(input logic [1:0] addr, input logic [4:0] rnum,
                                             input logic wr, input logic [15:0] data);
        logic [27:0] w;
        w = '0;
        w[22:21] = addr;
        w[20:16] = rnum;
        if (wr) begin
            w[CMD_WRITE_BIT] = 1'b1;
            w[15:0] = data;
        end else begin
            w[CMD_READ_BIT] = 1'b1;
        end
        return w;
    endfunction

endpackage

// ===== design/pmdio_seq.sv =====
// access sequencer: phase state, held request, timeout count and result logic
module pmdio_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  pmdio_pkg::t_item   i_item,
    input  logic               i_owned,
    input  logic [15:0]        i_timeout,
    output logic               o_res_valid,
    output pmdio_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEL  = 2'd1,
        PH_MAIN = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_addr, n_addr;
    logic [4:0]  r_reg, n_reg;
    logic [15:0] r_data, n_data;
    logic        r_write, n_write;
    logic [16:0] r_wait, n_wait;

    logic        page_ok;
    logic        req_bad;
    logic [1:0]  req_addr;
    logic [9:0]  sel_page;
    logic [31:0] got;
    logic [1:0]  want_addr;
    logic [4:0]  want_reg;
    logic [16:0] wait_inc;
    logic        busy;

    assign got      = i_item.mdic_read;
    assign page_ok  = (i_item.page == '0) ||
                      (i_item.page >= pmdio_pkg::HIGH_PAGE_LO &&
                       i_item.page <  pmdio_pkg::HIGH_PAGE_END);
    assign req_bad  = (i_item.phy_reg == pmdio_pkg::SELECT_REG) || !page_ok;
    assign req_addr = (i_item.page >= pmdio_pkg::HIGH_PAGE_LO) ? pmdio_pkg::ADDR_HIGH
                                                               : pmdio_pkg::ADDR_LOW;
    // page 768 selects as page 0
    assign sel_page = (i_item.page == pmdio_pkg::HIGH_PAGE_LO) ? '0 : i_item.page;
    assign want_addr = (r_phase == PH_SEL) ? pmdio_pkg::ADDR_HIGH : r_addr;
    assign want_reg  = (r_phase == PH_SEL) ? pmdio_pkg::SELECT_REG : r_reg;
    assign wait_inc  = r_wait + 17'd1;
    assign busy      = (r_phase != PH_IDLE);

    always_comb begin
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_data      = r_data;
        n_write     = r_write;
        n_wait      = r_wait;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            case (i_item.req_type)
                pmdio_pkg::REQ_ACCESS: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = pmdio_pkg::KIND_DONE;
                    if (busy) begin
                        o_res.status = pmdio_pkg::ST_BUSY;
                    end else if (req_bad) begin
                        o_res.status = pmdio_pkg::ST_BAD_REQ;
                    end else if (!i_owned) begin
                        o_res.status = pmdio_pkg::ST_NOT_OWN;
                    end else begin
                        n_addr     = req_addr;
                        n_reg      = i_item.phy_reg;
                        n_data     = i_item.write_data;
                        n_write    = i_item.is_write;
                        n_wait     = '0;
                        o_res.kind = pmdio_pkg::KIND_CMD;
                        if (i_item.phy_reg > pmdio_pkg::LAST_LOW_REG) begin
                            n_phase   = PH_SEL;
                            o_res.cmd = pmdio_pkg::make_cmd(pmdio_pkg::ADDR_HIGH,
                                            pmdio_pkg::SELECT_REG, 1'b1,
                                            {1'b0, sel_page, 5'd0});
                        end else begin
                            n_phase   = PH_MAIN;
                            o_res.cmd = pmdio_pkg::make_cmd(req_addr, i_item.phy_reg,
                                            i_item.is_write, i_item.write_data);
                        end
                    end
                end
                pmdio_pkg::REQ_READBACK: begin
                    if (busy) begin
                        o_res.kind = pmdio_pkg::KIND_DONE;
                        if (got == '1) begin
                            o_res_valid  = 1'b1;
                            o_res.status = pmdio_pkg::ST_ALL_ONES;
                        end else if (!got[pmdio_pkg::RB_READY_BIT]) begin
                            // not ready yet: keep waiting
                            o_res_valid = 1'b0;
                        end else if (got[pmdio_pkg::RB_ERROR_BIT]) begin
                            o_res_valid  = 1'b1;
                            o_res.status = pmdio_pkg::ST_ERR_BIT;
                        end else if (got[20:16] != want_reg ||
                                     got[25:21] != {3'b000, want_addr}) begin
                            o_res_valid  = 1'b1;
                            o_res.status = pmdio_pkg::ST_ECHO;
                        end else if (r_phase == PH_SEL) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = pmdio_pkg::KIND_CMD;
                            o_res.cmd   = pmdio_pkg::make_cmd(r_addr, r_reg, r_write, r_data);
                            n_phase     = PH_MAIN;
                        end else begin
                            o_res_valid  = 1'b1;
                            o_res.status = pmdio_pkg::ST_OK;
                            o_res.rdata  = r_write ? 16'd0 : got[15:0];
                        end
                        n_wait = '0;
                        if (o_res_valid && o_res.kind == pmdio_pkg::KIND_DONE) begin
                            n_phase = PH_IDLE;
                        end else if (!o_res_valid) begin
                            n_wait = r_wait;
                        end
                    end
                end
                pmdio_pkg::REQ_TICK: begin
                    if (busy) begin
                        if (wait_inc >= {1'b0, i_timeout}) begin
                            o_res_valid  = 1'b1;
                            o_res.kind   = pmdio_pkg::KIND_DONE;
                            o_res.status = pmdio_pkg::ST_TIMEOUT;
                            n_phase      = PH_IDLE;
                            n_wait       = '0;
                        end else begin
                            n_wait = wait_inc;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_reg   <= '0;
            r_data  <= '0;
            r_write <= 1'b0;
            r_wait  <= '0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_reg   <= n_reg;
            r_data  <= n_data;
            r_write <= n_write;
            r_wait  <= n_wait;
        end
    end

    // an access request while busy leaves the pending access alone
    a_busy_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && busy && i_item.req_type == pmdio_pkg::REQ_ACCESS |=> $stable(r_phase))
        else $error("busy reject disturbed the pending access");

    // any completion other than busy returns to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == pmdio_pkg::KIND_DONE &&
        o_res.status != pmdio_pkg::ST_BUSY |=> r_phase == PH_IDLE)
        else $error("completion did not end the access");

    // each issued command restarts the timeout count
    a_cmd_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == pmdio_pkg::KIND_CMD |=> r_wait == '0 && r_phase != PH_IDLE)
        else $error("command issued without restarting the wait count");

endmodule

// ===== design/paged_phy_mdio_access.sv =====
// top level of the paged phy mdio access sequencer
// Sequences one paged PHY register access through an MDIO command register. An input
// beat is an access request, a command register readback word or a time tick (tuser);
// an output beat is either a command word to write to the command register or an
// access completion (tuser). Registers above 15 first get a page-select write to PHY
// address 1, register 31; pages 768..799 use PHY address 1, page 0 address 2. Each
// command waits for a ready readback; all-ones, the error bit or an address/register
// echo mismatch fail the access, and timeout_ticks ticks without a good readback time
// it out. A request while an access is pending completes at once with busy status.
// Throughput is one beat per clock while the output is not stalled; an accepted beat passes
// through the input register, then the single-pass decision logic into the result register.
// A new beat is taken whenever the input register is empty or the result register is free
// or being drained, so a stalled output holds at most two beats before tready drops.
// Configuration writes are registered and belong to idle periods only; the user must keep
// to this, as the block does not enforce it.
module paged_phy_mdio_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // page[9:0], phy_reg, write_data, is_write, mdic_read
    input  logic [1:0]  s_axis_tuser,  // req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // mdic_command[27:0], status, read_data, zero pad
    output logic        m_axis_tuser   // out_kind
);

    // configuration registers
    logic        r_owned;
    logic [15:0] r_timeout;

    // input register
    logic             r_in_valid;
    pmdio_pkg::t_item r_in;

    // result register
    logic               r_out_valid;
    pmdio_pkg::t_result r_out;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic               res_valid;
    pmdio_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned   <= 1'b0;
            r_timeout <= pmdio_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pmdio_pkg::CFG_OWNED:   r_owned   <= i_cfg_wdata[0];
                pmdio_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                default:                r_owned   <= r_owned;
            endcase
        end
    end

    // the result register is free when empty or draining this clock
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload unpack, first field in the low bits
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type   <= s_axis_tuser;
            r_in.page       <= s_axis_tdata[9:0];
            r_in.phy_reg    <= s_axis_tdata[14:10];
            r_in.write_data <= s_axis_tdata[30:15];
            r_in.is_write   <= s_axis_tdata[31];
            r_in.mdic_read  <= s_axis_tdata[63:32];
        end
    end

    pmdio_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (r_in),
        .i_owned     (r_owned),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {1'b0, r_out.rdata, r_out.status, r_out.cmd};

    // command beats never carry status or read data
    a_cmd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == pmdio_pkg::KIND_CMD |->
        r_out.status == pmdio_pkg::ST_OK && r_out.rdata == '0)
        else $error("command beat with completion fields set");

    // an empty input register always takes a beat
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with an empty input register");

    // a stalled input register waits only on a full, blocked result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> r_out_valid && !m_axis_tready)
        else $error("input held without an output stall");

endmodule
